// File: rtl/tmi_pkg.sv
// Package for the tape machine interpreter: command, status and symbol codes,
// default depths and the control and status words between controller and datapath.
// No dependencies.
`default_nettype none

package tmi_pkg;

	// Default depths, handed to the top-level parameters.
	localparam int PROG_DEPTH_DEF  = 4096;
	localparam int TAPE_DEPTH_DEF  = 4096;
	localparam int STACK_DEPTH_DEF = 64;

	// Field widths fixed by the interface.
	localparam int CELL_W   = 32;
	localparam int SYM_W    = 8;
	localparam int INVAL_W  = 9;
	localparam int STATUS_W = 3;
	localparam int PCOUT_W  = 13;
	localparam int SKIP_W   = 7;

	localparam logic [SKIP_W-1:0] SKIP_MAX = 7'd127;

	// Commands carried by the cmd field.
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_STEP   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DONE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PTR   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STACK = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLOSE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd5;

	// Program symbols.
	localparam logic [SYM_W-1:0] SYM_INC   = 8'h2B; // +
	localparam logic [SYM_W-1:0] SYM_DEC   = 8'h2D; // -
	localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h3E; // >
	localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h3C; // <
	localparam logic [SYM_W-1:0] SYM_PUTC  = 8'h2E; // .
	localparam logic [SYM_W-1:0] SYM_PUTN  = 8'h3D; // =
	localparam logic [SYM_W-1:0] SYM_GET   = 8'h2C; // ,
	localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h5B; // [
	localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h5D; // ]

	// Controller states.
	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic sweep_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/tape_machine_interpreter_unit.sv
// Top level of the tape machine interpreter: joins the controller and the datapath.
// Depends on tmi_pkg, tmi_ctrl and tmi_datapath.
//
//   Channel   Handshake                  Fields
//   command   start, busy                cmd, symbol, in_value
//   result    done (one-cycle strobe)    out_valid, out_kind, out_value, status, pc_now
//
// A word is read, then executed: the accepting edge reads the program, tape and loop
// stack memories, and the execute cycle writes back and registers the result word,
// which stays on the result ports until the next execute cycle; unless the word was a
// clear, the next word may be accepted meanwhile. After reset and each clear word, busy
// stays high while the tape is zeroed one cell a cycle through its single write port.
// The receiver cannot stall; done marks each result word for exactly one cycle.
`default_nettype none

module tape_machine_interpreter_unit #(
	parameter int PROG_DEPTH  = tmi_pkg::PROG_DEPTH_DEF,
	parameter int TAPE_DEPTH  = tmi_pkg::TAPE_DEPTH_DEF,
	parameter int STACK_DEPTH = tmi_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         cmd,
	input  wire logic [tmi_pkg::SYM_W-1:0]          symbol,
	input  wire logic signed [tmi_pkg::INVAL_W-1:0] in_value,
	output logic                                    done,
	output logic                                    out_valid,
	output logic                                    out_kind,
	output logic signed [tmi_pkg::CELL_W-1:0]       out_value,
	output logic [tmi_pkg::STATUS_W-1:0]            status,
	output logic [tmi_pkg::PCOUT_W-1:0]             pc_now
);
	import tmi_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	tmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	tmi_datapath #(
		.PROG_DEPTH  (PROG_DEPTH),
		.TAPE_DEPTH  (TAPE_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cmd       (cmd),
		.symbol    (symbol),
		.in_value  (in_value),
		.done      (done),
		.out_valid (out_valid),
		.out_kind  (out_kind),
		.out_value (out_value),
		.status    (status),
		.pc_now    (pc_now)
	);

endmodule

`default_nettype wire

// File: rtl/tmi_ctrl.sv
// Controller for the tape machine interpreter: sequences the tape sweep,
// the memory read cycle and the execute cycle. Depends on tmi_pkg.
`default_nettype none

module tmi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tmi_pkg::dp_stat_t stat,
	output tmi_pkg::ctl_cmd_t      ctl,
	output logic                   busy
);
	import tmi_pkg::*;

	state_t state_q;
	state_t state_n;

	// State register; reset begins with a sweep that zeroes the tape.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		state_n     = state_q;
		ctl.capture = 1'b0;
		ctl.exec    = 1'b0;
		ctl.sweep   = 1'b0;
		busy        = 1'b1;
		case (state_q)
			S_SWEEP: begin
				ctl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.capture = 1'b1;
					state_n     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_n  = stat.is_clear ? S_SWEEP : S_IDLE;
			end
			default: begin
				state_n = S_SWEEP;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tmi_datapath.sv
// Datapath for the tape machine interpreter: program, tape and loop stack
// memories, machine registers, the execute logic and the result registers.
// Depends on tmi_pkg.
`default_nettype none

module tmi_datapath #(
	parameter int PROG_DEPTH  = tmi_pkg::PROG_DEPTH_DEF,
	parameter int TAPE_DEPTH  = tmi_pkg::TAPE_DEPTH_DEF,
	parameter int STACK_DEPTH = tmi_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tmi_pkg::ctl_cmd_t            ctl,
	output tmi_pkg::dp_stat_t                 stat,
	input  wire logic [1:0]                   cmd,
	input  wire logic [tmi_pkg::SYM_W-1:0]    symbol,
	input  wire logic signed [tmi_pkg::INVAL_W-1:0] in_value,
	output logic                              done,
	output logic                              out_valid,
	output logic                              out_kind,
	output logic signed [tmi_pkg::CELL_W-1:0] out_value,
	output logic [tmi_pkg::STATUS_W-1:0]      status,
	output logic [tmi_pkg::PCOUT_W-1:0]       pc_now
);
	import tmi_pkg::*;

	localparam int PAW = $clog2(PROG_DEPTH);
	localparam int PW  = PAW + 1;
	localparam int TAW = $clog2(TAPE_DEPTH);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SW  = SAW + 1;
	localparam logic [PW-1:0]  PROG_FULL  = PW'(PROG_DEPTH);
	localparam logic [TAW-1:0] TAPE_LAST  = TAW'(TAPE_DEPTH - 1);
	localparam logic [SW-1:0]  STACK_FULL = SW'(STACK_DEPTH);

	// Memories.
	logic [SYM_W-1:0]  prog_mem  [PROG_DEPTH];
	logic [CELL_W-1:0] tape_mem  [TAPE_DEPTH];
	logic [PW-1:0]     stack_mem [STACK_DEPTH];

	// Machine registers.
	logic [PW-1:0]       len_q, pc_q;
	logic [TAW-1:0]      dp_q;
	logic [SW-1:0]       sp_q;
	logic [SKIP_W-1:0]   skip_q;
	logic [STATUS_W-1:0] halt_q;
	logic [TAW-1:0]      sweep_q;

	// Captured input word.
	logic [1:0]         cmd_q;
	logic [SYM_W-1:0]   symbol_q;
	logic [INVAL_W-1:0] in_value_q;

	// Registered memory read data.
	logic [SYM_W-1:0]  sym_rd_q;
	logic [CELL_W-1:0] cell_rd_q;
	logic [PW-1:0]     top_rd_q;

	// Next values and write controls from the execute logic.
	logic [PW-1:0]       len_n, pc_n;
	logic [TAW-1:0]      dp_n;
	logic [SW-1:0]       sp_n;
	logic [SKIP_W-1:0]   skip_n;
	logic [STATUS_W-1:0] halt_n;
	logic                prog_we, tape_we, stack_we;
	logic [CELL_W-1:0]   cell_n;
	logic                valid_n, kind_n;
	logic [CELL_W-1:0]   value_n;
	logic [STATUS_W-1:0] status_n;
	logic                cell_zero;

	// Tape write port shared by the sweep and the execute cycle.
	logic              tape_wen;
	logic [TAW-1:0]    tape_wa;
	logic [CELL_W-1:0] tape_wd;

	assign stat.is_clear   = (cmd_q == CMD_CLEAR);
	assign stat.sweep_last = (sweep_q == TAPE_LAST);
	assign cell_zero       = (cell_rd_q == '0);

	// Input word capture.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			symbol_q   <= symbol;
			in_value_q <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_STEP;
		end else if (ctl.capture) begin
			cmd_q <= cmd;
		end
	end

	// Program memory: written on append, read at the program counter.
	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[len_q[PAW-1:0]] <= symbol_q;
		end
		sym_rd_q <= prog_mem[pc_q[PAW-1:0]];
	end

	// Tape memory: zeroed by the sweep, written by the execute cycle, read at the data pointer.
	always_comb begin
		tape_wen = ctl.sweep | (ctl.exec & tape_we);
		tape_wa  = ctl.sweep ? sweep_q : dp_q;
		tape_wd  = ctl.sweep ? '0 : cell_n;
	end

	always_ff @(posedge clk) begin
		if (tape_wen) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		cell_rd_q <= tape_mem[dp_q];
	end

	// Loop stack memory: pushed at the count, read at the top entry.
	always_ff @(posedge clk) begin
		if (ctl.exec && stack_we) begin
			stack_mem[sp_q[SAW-1:0]] <= pc_q;
		end
		top_rd_q <= stack_mem[SAW'(sp_q - 1'b1)];
	end

	// Sweep address counter; it rests at zero outside a sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctl.sweep && !stat.sweep_last) begin
			sweep_q <= sweep_q + 1'b1;
		end else begin
			sweep_q <= '0;
		end
	end

	// Execute logic for one word.
	always_comb begin
		len_n    = len_q;
		pc_n     = pc_q;
		dp_n     = dp_q;
		sp_n     = sp_q;
		skip_n   = skip_q;
		halt_n   = halt_q;
		prog_we  = 1'b0;
		tape_we  = 1'b0;
		stack_we = 1'b0;
		cell_n   = cell_rd_q;
		valid_n  = 1'b0;
		kind_n   = 1'b0;
		value_n  = '0;
		case (cmd_q)
			CMD_CLEAR: begin
				len_n  = '0;
				pc_n   = '0;
				dp_n   = '0;
				sp_n   = '0;
				skip_n = '0;
				halt_n = ST_RUN;
			end
			CMD_APPEND: begin
				if (halt_q == ST_RUN) begin
					if (len_q >= PROG_FULL) begin
						halt_n = ST_FULL;
					end else begin
						prog_we = 1'b1;
						len_n   = len_q + 1'b1;
					end
				end
			end
			CMD_STEP: begin
				if (halt_q == ST_RUN && pc_q < len_q) begin
					if (skip_q != '0) begin
						// Skipping forward to the matching close bracket.
						if (sym_rd_q == SYM_OPEN && skip_q >= SKIP_MAX) begin
							halt_n = ST_STACK;
						end else begin
							if (sym_rd_q == SYM_OPEN) begin
								skip_n = skip_q + 1'b1;
							end else if (sym_rd_q == SYM_CLOSE) begin
								skip_n = skip_q - 1'b1;
							end
							pc_n = pc_q + 1'b1;
						end
					end else begin
						case (sym_rd_q)
							SYM_INC: begin
								cell_n  = cell_rd_q + 1'b1;
								tape_we = 1'b1;
								pc_n    = pc_q + 1'b1;
							end
							SYM_DEC: begin
								cell_n  = cell_rd_q - 1'b1;
								tape_we = 1'b1;
								pc_n    = pc_q + 1'b1;
							end
							SYM_RIGHT: begin
								if (dp_q == TAPE_LAST) begin
									halt_n = ST_PTR;
								end else begin
									dp_n = dp_q + 1'b1;
									pc_n = pc_q + 1'b1;
								end
							end
							SYM_LEFT: begin
								if (dp_q == '0) begin
									halt_n = ST_PTR;
								end else begin
									dp_n = dp_q - 1'b1;
									pc_n = pc_q + 1'b1;
								end
							end
							SYM_PUTC: begin
								valid_n = 1'b1;
								value_n = cell_rd_q;
								pc_n    = pc_q + 1'b1;
							end
							SYM_PUTN: begin
								valid_n = 1'b1;
								kind_n  = 1'b1;
								value_n = cell_rd_q;
								pc_n    = pc_q + 1'b1;
							end
							SYM_GET: begin
								cell_n  = {{(CELL_W-INVAL_W){in_value_q[INVAL_W-1]}},
									in_value_q};
								tape_we = 1'b1;
								pc_n    = pc_q + 1'b1;
							end
							SYM_OPEN: begin
								if (cell_zero) begin
									skip_n = SKIP_W'(1);
									pc_n   = pc_q + 1'b1;
								end else if (sp_q >= STACK_FULL) begin
									halt_n = ST_STACK;
								end else begin
									stack_we = 1'b1;
									sp_n     = sp_q + 1'b1;
									pc_n     = pc_q + 1'b1;
								end
							end
							SYM_CLOSE: begin
								if (sp_q == '0) begin
									halt_n = ST_CLOSE;
								end else if (cell_zero) begin
									sp_n = sp_q - 1'b1;
									pc_n = pc_q + 1'b1;
								end else begin
									pc_n = top_rd_q + 1'b1;
								end
							end
							default: begin
								pc_n = pc_q + 1'b1;
							end
						endcase
					end
				end
			end
			default: begin
				// An unknown command changes nothing.
			end
		endcase

		// Status after this word.
		if (halt_n != ST_RUN) begin
			status_n = halt_n;
		end else if (pc_n >= len_n) begin
			status_n = ST_DONE;
		end else begin
			status_n = ST_RUN;
		end
	end

	// Machine registers, updated at the end of the execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pc_q   <= '0;
			dp_q   <= '0;
			sp_q   <= '0;
			skip_q <= '0;
			halt_q <= ST_RUN;
		end else if (ctl.exec) begin
			len_q  <= len_n;
			pc_q   <= pc_n;
			dp_q   <= dp_n;
			sp_q   <= sp_n;
			skip_q <= skip_n;
			halt_q <= halt_n;
		end
	end

	// Result word registers and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			out_valid <= valid_n;
			out_kind  <= kind_n;
			out_value <= value_n;
			status    <= status_n;
			pc_now    <= PCOUT_W'(pc_n);
		end
	end

endmodule

`default_nettype wire

// File: tb/tape_machine_interpreter_unit_tb.sv
// Self-checking testbench for tape_machine_interpreter_unit: directed programs, runs to
// the loop stack and skip nesting limits, then random programs with random idling.
// Depends on tmi_pkg and the RTL of the interpreter.
`timescale 1ns / 100ps

module tape_machine_interpreter_unit_tb;
	import tmi_pkg::*;

	localparam int PROG_N = PROG_DEPTH_DEF;
	localparam int TAPE_N = TAPE_DEPTH_DEF;
	localparam int STACK_N = STACK_DEPTH_DEF;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TOTAL_WORDS = 560;
	localparam int MAX_REPORTS = 10;

	typedef logic [SYM_W-1:0] sym_q_t [$];

	// One result word as the block presents it.
	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [CELL_W-1:0]   value;
		logic [STATUS_W-1:0] stat;
		logic [PCOUT_W-1:0]  pc;
	} step_result_t;

	// Interpreter state kept alongside the block, and the results still owed by it.
	class tape_scoreboard;
		logic [SYM_W-1:0]  prog_mem [PROG_N];
		logic [CELL_W-1:0] tape [TAPE_N];
		int unsigned       ret_pc [STACK_N];
		int unsigned       prog_len, pc, dptr, held, skip_level;
		logic [STATUS_W-1:0] halt_code;
		step_result_t      owed_q [$];
		int unsigned       checked, errors;

		function new();
			clear_machine();
			checked = 0;
			errors = 0;
		endfunction

		function void clear_machine();
			foreach (tape[i]) tape[i] = '0;
			prog_len = 0;
			pc = 0;
			dptr = 0;
			held = 0;
			skip_level = 0;
			halt_code = ST_RUN;
		endfunction

		function logic [STATUS_W-1:0] status_now();
			if (halt_code != ST_RUN)
				return halt_code;
			return (pc >= prog_len) ? ST_DONE : ST_RUN;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Works out the result of one accepted word and queues it.
		function void note_word(logic [1:0] c, logic [SYM_W-1:0] s,
				logic signed [INVAL_W-1:0] v);
			step_result_t r;
			logic [SYM_W-1:0] sym;
			r = '0;
			case (c)
			CMD_CLEAR: clear_machine();
			CMD_APPEND: begin
				if (halt_code == ST_RUN) begin
					if (prog_len >= PROG_N) begin
						halt_code = ST_FULL;
					end else begin
						prog_mem[prog_len] = s;
						prog_len++;
					end
				end
			end
			CMD_STEP: begin
				if (halt_code == ST_RUN && pc < prog_len) begin
					sym = prog_mem[pc];
					if (skip_level != 0) begin
						// Skipping a loop body: only brackets matter, for nesting.
						if (sym == SYM_OPEN && skip_level >= SKIP_MAX) begin
							halt_code = ST_STACK;
						end else begin
							if (sym == SYM_OPEN)
								skip_level++;
							else if (sym == SYM_CLOSE)
								skip_level--;
							pc++;
						end
					end else begin
						case (sym)
						SYM_INC: begin
							tape[dptr] = tape[dptr] + 1;
							pc++;
						end
						SYM_DEC: begin
							tape[dptr] = tape[dptr] - 1;
							pc++;
						end
						SYM_RIGHT: begin
							if (dptr + 1 >= TAPE_N) begin
								halt_code = ST_PTR;
							end else begin
								dptr++;
								pc++;
							end
						end
						SYM_LEFT: begin
							if (dptr == 0) begin
								halt_code = ST_PTR;
							end else begin
								dptr--;
								pc++;
							end
						end
						SYM_PUTC, SYM_PUTN: begin
							r.valid = 1'b1;
							r.kind = (sym == SYM_PUTN);
							r.value = tape[dptr];
							pc++;
						end
						SYM_GET: begin
							tape[dptr] = {{(CELL_W-INVAL_W){v[INVAL_W-1]}}, v};
							pc++;
						end
						SYM_OPEN: begin
							if (tape[dptr] == 0) begin
								skip_level = 1;
								pc++;
							end else if (held >= STACK_N) begin
								halt_code = ST_STACK;
							end else begin
								ret_pc[held] = pc;
								held++;
								pc++;
							end
						end
						SYM_CLOSE: begin
							if (held == 0) begin
								halt_code = ST_CLOSE;
							end else if (tape[dptr] == 0) begin
								held--;
								pc++;
							end else begin
								pc = ret_pc[held-1] + 1;
							end
						end
						default: pc++;
						endcase
					end
				end
			end
			default: ;
			endcase
			r.stat = status_now();
			r.pc = pc[PCOUT_W-1:0];
			owed_q.push_back(r);
		endfunction

		// Compares one result word with the oldest one owed.
		function void check_word(step_result_t got);
			step_result_t want;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result word with none expected: %p", $realtime, got);
				return;
			end
			want = owed_q.pop_front();
			checked++;
			if (got.valid !== want.valid || got.kind !== want.kind
					|| got.value !== want.value || got.stat !== want.stat
					|| got.pc !== want.pc) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: mismatch (expected/actual): valid %b/%b kind %b/%b",
						$realtime, want.valid, got.valid, want.kind, got.kind);
					$display("    value %0d/%0d status %0d/%0d pc %0d/%0d",
						$signed(want.value), $signed(got.value), want.stat, got.stat,
						want.pc, got.pc);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] cmd;
	logic [SYM_W-1:0] symbol;
	logic signed [INVAL_W-1:0] in_value;
	logic done;
	logic out_valid;
	logic out_kind;
	logic signed [CELL_W-1:0] out_value;
	logic [STATUS_W-1:0] status;
	logic [PCOUT_W-1:0] pc_now;

	tape_scoreboard sb = new;
	bit idle_on;
	int quiet_cycles;
	int n_clear, n_append, n_step, n_printed;
	sym_q_t prog;

	tape_machine_interpreter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.symbol    (symbol),
		.in_value  (in_value),
		.done      (done),
		.out_valid (out_valid),
		.out_kind  (out_kind),
		.out_value (out_value),
		.status    (status),
		.pc_now    (pc_now)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample both channels at each edge; also watch for the block going quiet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_word(step_result_t'({out_valid, out_kind, out_value, status, pc_now}));
				if (out_valid)
					n_printed++;
			end
			if (start && !busy) begin
				sb.note_word(cmd, symbol, in_value);
				case (cmd)
				CMD_CLEAR: n_clear++;
				CMD_APPEND: n_append++;
				CMD_STEP: n_step++;
				default: ;
				endcase
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic logic signed [INVAL_W-1:0] rand_in();
		if ($urandom_range(0, 7) == 0)
			return -1;
		return INVAL_W'($urandom_range(0, 255));
	endfunction

	// Random program with nested loops; the random bytes it mixes in may add unmatched brackets.
	function automatic sym_q_t gen_program(int len);
		sym_q_t q;
		int depth;
		depth = 0;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 19))
			5, 6: q.push_back(SYM_DEC);
			7, 8: q.push_back(SYM_RIGHT);
			9: q.push_back(SYM_LEFT);
			10: q.push_back(SYM_PUTC);
			11: q.push_back(SYM_PUTN);
			12: q.push_back(SYM_GET);
			13, 14: begin
				if (depth < 4) begin
					q.push_back(SYM_OPEN);
					depth++;
				end else begin
					q.push_back(SYM_INC);
				end
			end
			15, 16: begin
				if (depth > 0) begin
					q.push_back(SYM_CLOSE);
					depth--;
				end else begin
					q.push_back(SYM_DEC);
				end
			end
			17: q.push_back(SYM_W'($urandom_range(0, 255)));
			default: q.push_back(SYM_INC);
			endcase
		end
		while (depth > 0) begin
			q.push_back(SYM_CLOSE);
			depth--;
		end
		return q;
	endfunction

	// Offers one word and returns at the edge that accepts it.
	task automatic send_word(input logic [1:0] c, input logic [SYM_W-1:0] s,
			input logic signed [INVAL_W-1:0] v);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		symbol <= s;
		in_value <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic append_syms(input sym_q_t q);
		foreach (q[i])
			send_word(CMD_APPEND, q[i], rand_in());
	endtask

	task automatic run_steps(input int n);
		repeat (n)
			send_word(CMD_STEP, SYM_W'($urandom_range(0, 255)), rand_in());
	endtask

	task automatic clear_machine();
		send_word(CMD_CLEAR, SYM_W'($urandom_range(0, 255)), rand_in());
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Stimulus.
	initial begin
		int n;
		start = 1'b0;
		cmd = CMD_CLEAR;
		symbol = '0;
		in_value = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		quiet_cycles = 0;
		n_clear = 0;
		n_append = 0;
		n_step = 0;
		n_printed = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Unknown command and a step with no program.
		send_word(CMD_NONE, 8'hFF, -1);
		send_word(CMD_STEP, 8'h00, 9'sd255);

		// Wrap below zero, end-of-input read, both outputs, stray bytes, then < at cell 0.
		prog = '{SYM_DEC, SYM_PUTN, SYM_GET, SYM_PUTC, SYM_INC, SYM_PUTN, 8'h00, 8'hFF,
			SYM_LEFT};
		append_syms(prog);
		repeat (9)
			send_word(CMD_STEP, 8'h00, -1);
		// A halted machine ignores steps and appends.
		send_word(CMD_STEP, 8'hFF, 9'sd0);
		send_word(CMD_APPEND, SYM_INC, 9'sd0);
		send_word(CMD_NONE, 8'h00, 9'sd0);
		drain();

		// Close with nothing open.
		clear_machine();
		prog = '{SYM_CLOSE};
		append_syms(prog);
		run_steps(2);

		// Open on a zero cell skips the body; an unclosed skip runs off the end, and
		// appending afterwards carries on from where it stopped.
		clear_machine();
		prog = '{SYM_OPEN, SYM_INC, SYM_CLOSE, SYM_OPEN, SYM_PUTN};
		append_syms(prog);
		run_steps(6);
		prog = '{SYM_CLOSE, SYM_PUTN};
		append_syms(prog);
		run_steps(3);

		// A counted loop, then an open loop left at the program end.
		clear_machine();
		prog = '{SYM_INC, SYM_INC, SYM_INC, SYM_OPEN, SYM_PUTN, SYM_DEC, SYM_CLOSE,
			SYM_PUTN, SYM_INC, SYM_OPEN, SYM_INC};
		append_syms(prog);
		run_steps(20);

		// Loop stack overflow: one more nested open than the stack holds.
		clear_machine();
		prog = '{SYM_INC};
		repeat (STACK_N + 1) prog.push_back(SYM_OPEN);
		append_syms(prog);
		run_steps(STACK_N + 3);

		// Skip nesting overflow on a zero cell.
		clear_machine();
		prog = '{};
		repeat (int'(SKIP_MAX) + 1) prog.push_back(SYM_OPEN);
		append_syms(prog);
		run_steps(int'(SKIP_MAX) + 3);
		drain();

		// Random programs, with some noise and some runs carried on without a clear.
		while (n_clear + n_append + n_step < TOTAL_WORDS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(3, 10)) begin
					n = $urandom_range(1, 3);
					if ($urandom_range(0, 15) == 0)
						n = CMD_CLEAR;
					send_word(2'(n), SYM_W'($urandom_range(0, 255)), rand_in());
				end
			end else begin
				if ($urandom_range(0, 3) != 0)
					clear_machine();
				prog = gen_program($urandom_range(1, 16));
				append_syms(prog);
				run_steps($urandom_range(1, 60));
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		// Let the last results come back.
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d clear, %0d append and %0d step words; %0d printed a cell.",
			n_clear, n_append, n_step, n_printed);
		$display("Checked %0d result words, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
rtl/tmi_pkg.sv
rtl/tmi_ctrl.sv
rtl/tmi_datapath.sv
rtl/tape_machine_interpreter_unit.sv
tb/tape_machine_interpreter_unit_tb.sv
